/* hdl/rfdrt_pkg.sv */
// Shared types and constants for the rotated frame dirty region tracker.
`default_nettype none
package rfdrt_pkg;
   localparam int NATIVE_WIDTH     = 128;
   localparam int NATIVE_HEIGHT    = 250;
   localparam int CANVAS_BYTE_COLS = 32;

   typedef enum logic [1:0] {
      KIND_CANVAS  = 2'd0,
      KIND_COMMIT  = 2'd1,
      KIND_READ    = 2'd2,
      KIND_OUTCOME = 2'd3
   } kind_type;

   typedef enum logic [2:0] {
      ACT_NONE    = 3'd0,
      ACT_FULL    = 3'd1,
      ACT_FAST    = 3'd2,
      ACT_PARTIAL = 3'd3,
      ACT_READ    = 3'd4
   } action_type;

   typedef struct packed {
      kind_type   kind;
      logic [6:0] canvas_row;
      logic [4:0] canvas_byte_col;
      logic [7:0] pixel_byte;
      logic       full_mode;
      logic [11:0] native_address;
      logic       refresh_ok;
   } req_type;

   typedef struct packed {
      action_type action;
      logic [6:0] rect_x;
      logic [7:0] rect_y;
      logic [7:0] rect_width;
      logic [7:0] rect_height;
      logic [7:0] read_data;
      logic       do_initial_full;
      logic       load_lut;
   } rsp_type;

   localparam logic [7:0] BYTE_ONES = 8'hFF;
   localparam logic [7:0] INTERVAL_RESET = 8'd20;
endpackage
`default_nettype wire

/* hdl/rotated_frame_dirty_region_tracker_core.sv */
// Top level of the rotated frame dirty region tracker.
//  channel | direction | handshake
//  req_    | in        | req_valid / req_ready
//  rsp_    | out       | rsp_valid / rsp_ready
//  csr_    | in        | csr_write_enable, no wait
// The front takes one word per cycle while the queue has room. In the back end
// commits, outcomes and unchanged bytes finish on acceptance, a read adds a frame
// read phase, and a changed canvas byte is walked bit by bit with a read and
// write-back per changed bit. After reset a clearing pass sweeps both stores while
// req_ready is low. No word enters the back end while a result is held on rsp_; a
// two-word queue between cache compare and frame update lets the front run until full.
`default_nettype none
module rotated_frame_dirty_region_tracker_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_kind,
   input  wire logic [6:0]  req_canvas_row,
   input  wire logic [4:0]  req_canvas_byte_col,
   input  wire logic [7:0]  req_pixel_byte,
   input  wire logic        req_full_mode,
   input  wire logic [11:0] req_native_address,
   input  wire logic        req_refresh_ok,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_action,
   output logic [6:0]       rsp_rect_x,
   output logic [7:0]       rsp_rect_y,
   output logic [7:0]       rsp_rect_width,
   output logic [7:0]       rsp_rect_height,
   output logic [7:0]       rsp_read_data,
   output logic             rsp_do_initial_full,
   output logic             rsp_load_lut,
   input  wire logic        csr_write_enable,
   input  wire logic [7:0]  csr_write_data
);
   import rfdrt_pkg::*;
   localparam int QW = $bits(req_type) + 8;

   req_type req_word, f_word, b_word;
   rsp_type rsp_word;
   logic [7:0] f_diff, b_diff;
   logic [QW-1:0] q_out;
   logic f_valid, f_ready, q_valid, q_ready, f_busy;
   logic [7:0] interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= INTERVAL_RESET;
      end else if (csr_write_enable) begin
         interval_ff <= csr_write_data;
      end
   end

   always_comb begin
      req_word.kind = kind_type'(req_kind);
      req_word.canvas_row = req_canvas_row;
      req_word.canvas_byte_col = req_canvas_byte_col;
      req_word.pixel_byte = req_pixel_byte;
      req_word.full_mode = req_full_mode;
      req_word.native_address = req_native_address;
      req_word.refresh_ok = req_refresh_ok;
   end

   rfdrt_front u_front (
      .clock(clock), .reset(reset), .in_valid(req_valid), .in_ready(req_ready),
      .in_word(req_word), .out_valid(f_valid), .out_ready(f_ready),
      .out_word(f_word), .out_diff(f_diff), .busy(f_busy)
   );

   rfdrt_fifo #(.WIDTH(QW)) u_queue (
      .clock(clock), .reset(reset), .in_valid(f_valid), .in_ready(f_ready),
      .in_data({f_word, f_diff}), .out_valid(q_valid), .out_ready(q_ready),
      .out_data(q_out)
   );

   assign {b_word, b_diff} = q_out;

   rfdrt_back u_back (
      .clock(clock), .reset(reset), .interval(interval_ff), .in_valid(q_valid),
      .in_ready(q_ready), .in_word(b_word), .in_diff(b_diff), .clear_busy(f_busy),
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_word(rsp_word)
   );

   assign rsp_action = rsp_word.action;
   assign rsp_rect_x = rsp_word.rect_x;
   assign rsp_rect_y = rsp_word.rect_y;
   assign rsp_rect_width = rsp_word.rect_width;
   assign rsp_rect_height = rsp_word.rect_height;
   assign rsp_read_data = rsp_word.read_data;
   assign rsp_do_initial_full = rsp_word.do_initial_full;
   assign rsp_load_lut = rsp_word.load_lut;
endmodule
`default_nettype wire

/* hdl/rfdrt_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rfdrt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

/* hdl/rfdrt_fifo.sv */
// Two-entry word queue between front and back.
`default_nettype none
module rfdrt_fifo #(
   parameter int WIDTH = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire logic [WIDTH-1:0] in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output logic      [WIDTH-1:0] out_data
);
   logic [WIDTH-1:0] data_ff [2];
   logic [WIDTH-1:0] data_in [2];
   logic [1:0] count_ff, count_in;
   logic push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = data_ff[0];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      data_in = data_ff;
      count_in = count_ff;
      if (pop) begin
         data_in[0] = data_ff[1];
      end
      if (push) begin
         if (count_ff == 2'd0 || (count_ff == 2'd1 && pop)) begin
            data_in[0] = in_data;
         end else if (pop) begin
            data_in[1] = in_data;
         end else begin
            data_in[1] = in_data;
         end
      end
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

/* hdl/rfdrt_front.sv */
// Front: clearing pass, canvas cache compare, per-byte change mask.
`default_nettype none
module rfdrt_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire rfdrt_pkg::req_type in_word,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output rfdrt_pkg::req_type     out_word,
   output logic [7:0]             out_diff,
   output logic                   busy
);
   import rfdrt_pkg::*;
   localparam int CW = $clog2(CANVAS_BYTE_COLS) > 0 ? $clog2(CANVAS_BYTE_COLS) : 1;
   localparam int RW = $clog2(NATIVE_WIDTH);
   localparam int DEPTH = NATIVE_WIDTH * CANVAS_BYTE_COLS;
   localparam int AW = $clog2(DEPTH);

   // stage 1 holds the item while the cache read is in flight
   logic        s1_valid_ff, s1_valid_in;
   req_type     s1_word_ff;
   logic        s1_inrange_ff;
   logic [AW:0] clr_ff, clr_in;
   logic        clearing;
   logic        s1_adv, take;
   logic [AW-1:0] in_addr, rd_addr, wr_addr, s1_addr_ff;
   logic [7:0]  rd_data, wr_data;
   logic        wr_en, inrange;
   logic [7:0]  old_byte;
   logic        fwd_ff;
   logic [7:0]  fwd_data_ff;

   assign clearing = (clr_ff != DEPTH[AW:0]);
   assign busy = clearing;
   assign s1_adv = !s1_valid_ff || out_ready;
   assign in_ready = s1_adv && !clearing;
   assign take = in_valid && in_ready;
   assign inrange = ({1'b0, in_word.canvas_byte_col} < 6'(CANVAS_BYTE_COLS)) &&
                    ({2'b00, in_word.canvas_row} < 9'(NATIVE_WIDTH));
   assign in_addr = AW'(in_word.canvas_row[RW-1:0]) * AW'(CANVAS_BYTE_COLS)
                    + AW'(in_word.canvas_byte_col[CW-1:0]);
   // hold the read address while stage 1 waits
   assign rd_addr = s1_adv ? in_addr : s1_addr_ff;
   assign old_byte = fwd_ff ? fwd_data_ff : rd_data;

   always_comb begin
      wr_en = 1'b0;
      wr_addr = s1_addr_ff;
      wr_data = s1_word_ff.pixel_byte;
      clr_in = clr_ff;
      s1_valid_in = s1_valid_ff;
      if (clearing) begin
         wr_en = 1'b1;
         wr_addr = clr_ff[AW-1:0];
         wr_data = BYTE_ONES;
         clr_in = clr_ff + 1'b1;
      end else if (s1_valid_ff && out_ready && s1_word_ff.kind == KIND_CANVAS
                   && s1_inrange_ff) begin
         wr_en = 1'b1;
      end
      if (s1_adv) begin
         s1_valid_in = take;
      end
   end

   rfdrt_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_cache (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (s1_adv) begin
         s1_word_ff <= in_word;
         s1_inrange_ff <= inrange;
         s1_addr_ff <= rd_addr;
         fwd_ff <= wr_en && !clearing && wr_addr == rd_addr;
         fwd_data_ff <= wr_data;
      end
      if (reset) begin
         s1_valid_ff <= 1'b0;
         clr_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         clr_ff <= clr_in;
      end
   end

   assign out_valid = s1_valid_ff;
   always_comb begin
      out_word = s1_word_ff;
      out_diff = (s1_word_ff.kind == KIND_CANVAS && s1_inrange_ff) ?
                 (old_byte ^ s1_word_ff.pixel_byte) : 8'd0;
   end
endmodule
`default_nettype wire

/* hdl/rfdrt_back.sv */
// Back: frame store updates, dirty box, commit decisions and reads.
`default_nettype none
module rfdrt_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [7:0]        interval,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire rfdrt_pkg::req_type in_word,
   input  wire logic [7:0]        in_diff,
   input  wire logic              clear_busy,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output rfdrt_pkg::rsp_type     out_word
);
   import rfdrt_pkg::*;
   localparam int ROW_BYTES = NATIVE_WIDTH / 8;
   localparam int FRAME = ROW_BYTES * NATIVE_HEIGHT;
   localparam int AW = $clog2(FRAME);
   localparam int BW = $clog2(ROW_BYTES) > 0 ? $clog2(ROW_BYTES) : 1;

   // bit-serial walk over the eight bits of one changed canvas byte
   logic        walk_ff, walk_in;
   logic [2:0]  bit_ff, bit_in;
   req_type     cur_ff;
   logic [7:0]  diff_ff;
   logic        rd_ph_ff, rd_ph_in;
   logic        rv_ff, rv_in;
   logic [AW:0] clr_ff, clr_in;
   logic        clearing;
   logic        wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [7:0]  wr_data, rd_data;
   logic        dirty_ff, dirty_in;
   logic [7:0]  fc_ff, fc_in, lc_ff, lc_in, fr_ff, fr_in, lr_ff, lr_in;
   logic [7:0]  psf_ff, psf_in;
   logic        init_ff, init_in, lut_ff, lut_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_v_ff, rsp_v_in;
   logic        accept;
   logic [6:0]  nx;
   logic [BW-1:0] bc;
   logic [7:0]  setmask;
   logic [9:0]  ny;
   logic [AW-1:0] fidx;
   logic [8:0]  cols, rows;
   logic [16:0] area;
   logic        rd_inrange_ff;

   assign clearing = (clr_ff != FRAME[AW:0]);
   assign nx = 7'(NATIVE_WIDTH - 1) - cur_ff.canvas_row;
   assign bc = BW'(nx >> 3);
   assign setmask = 8'h80 >> nx[2:0];
   assign ny = 10'({cur_ff.canvas_byte_col, bit_ff});
   assign fidx = AW'(ny) * AW'(ROW_BYTES) + AW'(bc);
   assign cols = {1'b0, lc_ff} - {1'b0, fc_ff} + 9'd1;
   assign rows = {1'b0, lr_ff} - {1'b0, fr_ff} + 9'd1;
   assign area = 17'(cols) * 17'(rows);
   assign in_ready = !walk_ff && !rd_ph_ff && !rv_ff && !clearing && !clear_busy &&
                     (!rsp_v_ff || out_ready);
   assign accept = in_valid && in_ready;
   assign out_valid = rsp_v_ff;
   assign out_word = rsp_ff;

   rfdrt_ram #(.WIDTH(8), .DEPTH(FRAME)) u_frame (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   always_comb begin
      walk_in = walk_ff; bit_in = bit_ff; rd_ph_in = 1'b0; rv_in = rv_ff;
      clr_in = clr_ff; wr_en = 1'b0; wr_addr = fidx; wr_data = rd_data;
      rd_addr = fidx;
      dirty_in = dirty_ff; fc_in = fc_ff; lc_in = lc_ff; fr_in = fr_ff; lr_in = lr_ff;
      psf_in = psf_ff; init_in = init_ff; lut_in = lut_ff;
      rsp_in = rsp_ff; rsp_v_in = rsp_v_ff;
      if (rsp_v_ff && out_ready) begin
         rsp_v_in = 1'b0;
      end
      if (clearing) begin
         wr_en = 1'b1;
         wr_addr = clr_ff[AW-1:0];
         wr_data = BYTE_ONES;
         clr_in = clr_ff + 1'b1;
      end else if (rd_ph_ff) begin
         // read data arrives; write it back and grow the box
         wr_data = cur_ff.pixel_byte[3'd7 - bit_ff] ? (rd_data | setmask)
                                                    : (rd_data & ~setmask);
         wr_en = 1'b1;
         if (!dirty_ff) begin
            fc_in = 8'(bc); lc_in = 8'(bc); fr_in = 8'(ny); lr_in = 8'(ny);
            dirty_in = 1'b1;
         end else begin
            if (8'(bc) < fc_ff) fc_in = 8'(bc);
            if (8'(bc) > lc_ff) lc_in = 8'(bc);
            if (8'(ny) < fr_ff) fr_in = 8'(ny);
            if (8'(ny) > lr_ff) lr_in = 8'(ny);
         end
         if (bit_ff == 3'd7) walk_in = 1'b0;
         bit_in = bit_ff + 3'd1;
      end else if (walk_ff) begin
         if (diff_ff[3'd7 - bit_ff] && ny < 10'(NATIVE_HEIGHT)
             && {1'b0, nx} < 8'(NATIVE_WIDTH)) begin
            rd_ph_in = 1'b1;
         end else begin
            if (bit_ff == 3'd7) walk_in = 1'b0;
            bit_in = bit_ff + 3'd1;
         end
      end
      if (rv_ff) begin
         rsp_in = '0;
         rsp_in.action = ACT_READ;
         rsp_in.read_data = rd_inrange_ff ? rd_data : 8'd0;
         rsp_v_in = 1'b1;
         rv_in = 1'b0;
      end
      if (accept) begin
         unique case (in_word.kind)
            KIND_CANVAS: begin
               if (in_diff != 8'd0) begin
                  walk_in = 1'b1;
                  bit_in = 3'd0;
               end
            end
            KIND_OUTCOME: begin
               if (in_word.refresh_ok && psf_ff != 8'd255) psf_in = psf_ff + 8'd1;
            end
            KIND_READ: begin
               rd_addr = in_word.native_address[AW-1:0];
               rv_in = 1'b1;
            end
            KIND_COMMIT: begin
               rsp_in = '0;
               rsp_v_in = 1'b1;
               if (in_word.full_mode || (dirty_ff && interval != 8'd0 &&
                                         psf_ff >= interval)) begin
                  rsp_in.action = ACT_FULL;
                  init_in = 1'b1; lut_in = 1'b0; psf_in = 8'd0;
               end else if (dirty_ff) begin
                  rsp_in.action = (area > 17'(FRAME / 2)) ? ACT_FAST : ACT_PARTIAL;
                  if (!init_ff) begin
                     rsp_in.do_initial_full = 1'b1;
                     init_in = 1'b1; psf_in = 8'd0;
                  end
                  rsp_in.load_lut = !lut_ff;
                  lut_in = 1'b1;
               end
               if (dirty_ff && rsp_in.action != ACT_NONE) begin
                  rsp_in.rect_x = 7'({fc_ff, 3'b000});
                  rsp_in.rect_y = fr_ff;
                  rsp_in.rect_width = 8'({cols, 3'b000});
                  rsp_in.rect_height = rows[7:0];
               end
               dirty_in = 1'b0; fc_in = 8'd15; lc_in = 8'd0;
               fr_in = 8'd255; lr_in = 8'd0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
      bit_ff <= bit_in;
      if (accept) begin
         cur_ff <= in_word;
         diff_ff <= in_diff;
         rd_inrange_ff <= in_word.native_address < 12'(FRAME);
      end
      if (reset) begin
         walk_ff <= 1'b0; rd_ph_ff <= 1'b0; rv_ff <= 1'b0; clr_ff <= '0;
         dirty_ff <= 1'b0; psf_ff <= 8'd0; init_ff <= 1'b0; lut_ff <= 1'b0;
         rsp_v_ff <= 1'b0;
         fc_ff <= 8'd15; lc_ff <= 8'd0; fr_ff <= 8'd255; lr_ff <= 8'd0;
      end else begin
         walk_ff <= walk_in; rd_ph_ff <= rd_ph_in; rv_ff <= rv_in; clr_ff <= clr_in;
         dirty_ff <= dirty_in; psf_ff <= psf_in; init_ff <= init_in; lut_ff <= lut_in;
         rsp_v_ff <= rsp_v_in;
         fc_ff <= fc_in; lc_ff <= lc_in; fr_ff <= fr_in; lr_ff <= lr_in;
      end
   end
endmodule
`default_nettype wire

/* dv/tb_top.sv */
// Self-checking testbench for the rotated frame dirty region tracker core.
`default_nettype none
module tb_top;
   import rfdrt_pkg::*;

   localparam int ROW_BYTES   = 16;
   localparam int FRAME_BYTES = 4000;
   localparam int CYCLE_LIMIT = 2000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [2:0] rsp_action;
   logic [6:0] rsp_rect_x;
   logic [7:0] rsp_rect_y, rsp_rect_width, rsp_rect_height, rsp_read_data;
   logic       rsp_do_initial_full, rsp_load_lut;
   rsp_type rsp_word;
   rsp_type exp_rsp;
   logic csr_write_enable = 1'b0;
   logic [7:0] csr_write_data = '0;

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   rotated_frame_dirty_region_tracker_core uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_kind(req_word.kind), .req_canvas_row(req_word.canvas_row),
      .req_canvas_byte_col(req_word.canvas_byte_col),
      .req_pixel_byte(req_word.pixel_byte), .req_full_mode(req_word.full_mode),
      .req_native_address(req_word.native_address),
      .req_refresh_ok(req_word.refresh_ok),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_action(rsp_action), .rsp_rect_x(rsp_rect_x),
      .rsp_rect_y(rsp_rect_y), .rsp_rect_width(rsp_rect_width),
      .rsp_rect_height(rsp_rect_height), .rsp_read_data(rsp_read_data),
      .rsp_do_initial_full(rsp_do_initial_full), .rsp_load_lut(rsp_load_lut),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   always_comb begin
      rsp_word.action = action_type'(rsp_action);
      rsp_word.rect_x = rsp_rect_x;
      rsp_word.rect_y = rsp_rect_y;
      rsp_word.rect_width = rsp_rect_width;
      rsp_word.rect_height = rsp_rect_height;
      rsp_word.read_data = rsp_read_data;
      rsp_word.do_initial_full = rsp_do_initial_full;
      rsp_word.load_lut = rsp_load_lut;
   end

   // tracker shadow state
   logic [7:0] interval_reg;
   logic [7:0] cache_mem [4096];
   logic [7:0] frame_mem [FRAME_BYTES];
   logic       box_dirty;
   int         first_col, last_col, first_row, last_row;
   logic [7:0] refresh_count;
   logic       initial_done, lut_loaded;

   req_type pending_words[$];
   rsp_type expected_rsps[$];
   int  send_idle_pct = 0, recv_idle_pct = 0;
   int  mismatches = 0;
   int  cycles = 0;
   bit  failed = 1'b0;

   task automatic shadow_reset();
      interval_reg = INTERVAL_RESET;
      foreach (cache_mem[i]) cache_mem[i] = BYTE_ONES;
      foreach (frame_mem[i]) frame_mem[i] = BYTE_ONES;
      box_dirty = 1'b0; first_col = 15; last_col = 0; first_row = 255; last_row = 0;
      refresh_count = '0; initial_done = 1'b0; lut_loaded = 1'b0;
   endtask

   task automatic grow(int col, int row);
      if (!box_dirty) begin
         first_col = col; last_col = col; first_row = row; last_row = row;
         box_dirty = 1'b1;
      end else begin
         if (col < first_col) first_col = col;
         if (col > last_col) last_col = col;
         if (row < first_row) first_row = row;
         if (row > last_row) last_row = row;
      end
   endtask

   task automatic mark_full();
      initial_done = 1'b1; lut_loaded = 1'b0; refresh_count = '0;
   endtask

   task automatic predict_word(req_type w);
      rsp_type r;
      int idx, nx, bc, ny, cols, rows;
      logic [7:0] ob, nb, mask;
      r = '0;
      case (w.kind)
         KIND_CANVAS: begin
            if (w.canvas_byte_col < 32 && w.canvas_row < 128) begin
               idx = w.canvas_row * 32 + w.canvas_byte_col;
               ob = cache_mem[idx];
               nb = w.pixel_byte;
               if (ob != nb) begin
                  nx = 127 - w.canvas_row;
                  bc = nx >> 3;
                  mask = 8'h80 >> (nx & 7);
                  for (int b = 0; b < 8; b++) begin
                     ny = w.canvas_byte_col * 8 + b;
                     if (ny < 250 && ((nb ^ ob) & (8'h80 >> b)) != 0 && bc < ROW_BYTES) begin
                        if (nb & (8'h80 >> b)) frame_mem[ny * ROW_BYTES + bc] |= mask;
                        else frame_mem[ny * ROW_BYTES + bc] &= ~mask;
                        grow(bc, ny);
                     end
                  end
                  cache_mem[idx] = nb;
               end
            end
         end
         KIND_OUTCOME: begin
            if (w.refresh_ok && refresh_count != 8'd255) refresh_count++;
         end
         KIND_READ: begin
            r.action = ACT_READ;
            r.read_data = w.native_address < FRAME_BYTES ? frame_mem[w.native_address] : '0;
            expected_rsps.push_back(r);
         end
         default: begin
            cols = last_col - first_col + 1;
            rows = last_row - first_row + 1;
            r.action = ACT_NONE;
            if (w.full_mode || (box_dirty && interval_reg != 0
                                && refresh_count >= interval_reg)) begin
               r.action = ACT_FULL;
               mark_full();
            end else if (box_dirty) begin
               r.action = (cols * rows > FRAME_BYTES / 2) ? ACT_FAST : ACT_PARTIAL;
               if (!initial_done) begin
                  r.do_initial_full = 1'b1;
                  mark_full();
               end
               r.load_lut = !lut_loaded;
               lut_loaded = 1'b1;
            end
            if (box_dirty && r.action != ACT_NONE) begin
               r.rect_x = 7'(first_col * 8);
               r.rect_y = 8'(first_row);
               r.rect_width = 8'(cols * 8);
               r.rect_height = 8'(rows);
            end
            box_dirty = 1'b0; first_col = 15; last_col = 0; first_row = 255; last_row = 0;
            expected_rsps.push_back(r);
         end
      endcase
   endtask

   function automatic req_type make_canvas(int row, int col, int pix);
      req_type w;
      w = req_type'($urandom());
      w.kind = KIND_CANVAS;
      w.canvas_row = 7'(row); w.canvas_byte_col = 5'(col); w.pixel_byte = 8'(pix);
      return w;
   endfunction

   function automatic req_type make_word(kind_type k);
      req_type w;
      w = req_type'({$urandom(), $urandom()});
      w.kind = k;
      if (k == KIND_READ && $urandom_range(0, 3) != 0)
         w.native_address = 12'($urandom_range(0, FRAME_BYTES - 1));
      return w;
   endfunction

   // monitor
   always @(posedge clock) begin
      if (!reset) begin
         cycles <= cycles + 1;
         if (req_valid && req_ready) begin
            predict_word(req_word);
            void'(pending_words.pop_front());
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_rsps.size() == 0) begin
               failed = 1'b1;
               if (mismatches < 10)
                  $display("unexpected response action=%0d", rsp_word.action);
               mismatches++;
            end else begin
               exp_rsp = expected_rsps[0];
               if (rsp_word !== exp_rsp) begin
                  failed = 1'b1;
                  if (mismatches < 10) begin
                     $display("mismatch expected act=%0d x=%0d y=%0d w=%0d h=%0d rd=%0h %0b %0b",
                        exp_rsp.action, exp_rsp.rect_x, exp_rsp.rect_y,
                        exp_rsp.rect_width, exp_rsp.rect_height, exp_rsp.read_data,
                        exp_rsp.do_initial_full, exp_rsp.load_lut);
                     $display("         actual   act=%0d x=%0d y=%0d w=%0d h=%0d rd=%0h %0b %0b",
                        rsp_word.action, rsp_word.rect_x, rsp_word.rect_y,
                        rsp_word.rect_width, rsp_word.rect_height, rsp_word.read_data,
                        rsp_word.do_initial_full, rsp_word.load_lut);
                  end
                  mismatches++;
               end
               void'(expected_rsps.pop_front());
            end
         end
         if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
      end
   end

   // remember acceptance seen at the last rising edge
   logic req_ready_q = 1'b0;
   logic send_hold;
   always @(posedge clock) req_ready_q <= req_valid && req_ready;

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         rsp_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
         if (!req_valid || req_ready_q) begin
            send_hold = ($urandom_range(0, 99) < send_idle_pct);
            if (pending_words.size() > 0 && !send_hold) begin
               req_word <= pending_words[0];
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic wait_drained();
      while (pending_words.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
   endtask

   task automatic write_interval(logic [7:0] v);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= v;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      interval_reg = v;
   endtask

   task automatic queue_frame(int n);
      int row0, col0;
      row0 = $urandom_range(0, 127);
      col0 = $urandom_range(0, 31);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(0, 9) == 0)
            pending_words.push_back(make_word(kind_type'($urandom_range(2, 3))));
         else if ($urandom_range(0, 3) == 0)
            pending_words.push_back(make_canvas($urandom_range(0, 127),
                                                $urandom_range(0, 31), $urandom()));
         else
            pending_words.push_back(make_canvas((row0 + $urandom_range(0, 7)) % 128,
                                                (col0 + $urandom_range(0, 3)) % 32,
                                                $urandom()));
      end
      if ($urandom_range(0, 1)) begin
         req_type w;
         w = make_word(KIND_OUTCOME); w.refresh_ok = 1'b1;
         pending_words.push_back(w);
      end
      pending_words.push_back(make_word(KIND_COMMIT));
   endtask

   initial begin
      req_type w;
      shadow_reset();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reads of untouched frame, extremes, commit with nothing dirty
      w = make_word(KIND_COMMIT); w.full_mode = 1'b0; pending_words.push_back(w);
      w = make_word(KIND_READ); w.native_address = 12'd0; pending_words.push_back(w);
      w = make_word(KIND_READ); w.native_address = 12'd3999; pending_words.push_back(w);
      w = make_word(KIND_READ); w.native_address = 12'd4095; pending_words.push_back(w);
      pending_words.push_back(make_canvas(0, 0, 8'h00));
      pending_words.push_back(make_canvas(127, 31, 8'h00));
      pending_words.push_back(make_canvas(127, 31, 8'h00));
      pending_words.push_back(make_canvas(64, 31, 8'hA5));
      w = make_word(KIND_READ); w.native_address = 12'd0; pending_words.push_back(w);
      w = make_word(KIND_READ); w.native_address = 12'd3999; pending_words.push_back(w);
      w = make_word(KIND_COMMIT); w.full_mode = 1'b0; pending_words.push_back(w);
      pending_words.push_back(make_canvas(5, 2, 8'h3C));
      w = make_word(KIND_COMMIT); w.full_mode = 1'b0; pending_words.push_back(w);
      for (int i = 0; i < 4; i++) begin
         w = make_word(KIND_OUTCOME); w.refresh_ok = 1'b1; pending_words.push_back(w);
      end
      w = make_word(KIND_OUTCOME); w.refresh_ok = 1'b0; pending_words.push_back(w);
      pending_words.push_back(make_canvas(10, 10, 8'hFF));
      w = make_word(KIND_COMMIT); w.full_mode = 1'b1; pending_words.push_back(w);
      w = make_word(KIND_COMMIT); w.full_mode = 1'b1; pending_words.push_back(w);
      wait_drained();

      // large box for the fast whole-frame action
      for (int c = 0; c < 32; c += 31) begin
         pending_words.push_back(make_canvas(0, c, 8'h00));
         pending_words.push_back(make_canvas(127, c, 8'h00));
      end
      w = make_word(KIND_COMMIT); w.full_mode = 1'b0; pending_words.push_back(w);
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase % 3)
            0: begin send_idle_pct = 6; recv_idle_pct = 57; end
            1: begin send_idle_pct = 57; recv_idle_pct = 6; end
            default: begin send_idle_pct = 0; recv_idle_pct = 0; end
         endcase
         case (phase)
            0: write_interval(8'd0);
            1: write_interval(8'd1);
            2: write_interval(8'd255);
            3: write_interval(8'd3);
            default: write_interval(8'($urandom_range(0, 255)));
         endcase
         for (int f = 0; f < 25; f++) begin
            queue_frame($urandom_range(1, 14));
            if ($urandom_range(0, 2) == 0)
               for (int k = 0; k < $urandom_range(1, 8); k++) begin
                  w = make_word(KIND_OUTCOME); w.refresh_ok = 1'b1;
                  pending_words.push_back(w);
               end
         end
         wait_drained();
      end

      if (!failed && mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
hdl/rfdrt_pkg.sv
hdl/rfdrt_ram.sv
hdl/rfdrt_fifo.sv
hdl/rfdrt_front.sv
hdl/rfdrt_back.sv
hdl/rotated_frame_dirty_region_tracker_core.sv
dv/tb_top.sv
